// ===== design/pipsc_pkg.sv =====
// types, constants and derived widths for the pi position to speed controller
package pipsc_pkg;

  // position span in rotation units and speed limit
  localparam int POS_SPAN    = 65535;
  localparam int SPEED_LIMIT = 1000;

  localparam int POS_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int DB_W    = 17;
  localparam int MINS_W  = 10;
  localparam int SPD_OUT_W = 11;
  localparam int INT_W   = 40;
  localparam int OUT_MAX = 1023;

  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK   = 3'd5;

  // degrees q8 per full span: 360 * 256
  localparam int DEG_SCALE = 360 * 256;
  localparam longint SPAN_EFF = (POS_SPAN < 1) ? 64'd1 : 64'(POS_SPAN);
  localparam longint NUM_MAX  = 64'd65535 * 64'(DEG_SCALE);
  localparam longint QUO_MAX  = NUM_MAX / SPAN_EFF;

  localparam int QW     = $clog2(QUO_MAX + 64'd1);
  localparam int SPAN_W = $clog2(SPAN_EFF + 64'd1);

  // scaled reciprocal of the span, rounded up; floor(mag * RCP >> RCP_SH)
  // equals floor(mag * DEG_SCALE / span) for every 16 bit magnitude
  localparam int     RCP_SH = POS_W + SPAN_W;
  localparam longint RCP    = ((64'(DEG_SCALE) << RCP_SH) + SPAN_EFF - 64'd1) / SPAN_EFF;
  localparam int     RCP_W  = $clog2(RCP + 64'd1);
  localparam int     RCP_N  = (RCP_W + GAIN_W - 1) / GAIN_W;
  localparam logic [RCP_N*GAIN_W-1:0] RCP_V = (RCP_N*GAIN_W)'(RCP);
  localparam int     CNT_W  = $clog2(RCP_N + 1);

  localparam int ERR_W  = QW + 1;
  localparam int MUL_AW = (ERR_W > 21) ? ERR_W : 21;
  localparam int PROD_W = MUL_AW + GAIN_W + 1;
  localparam int ACC_W  = ((ERR_W > INT_W) ? ERR_W : INT_W) + GAIN_W + 2;
  localparam int SPD_W  = ACC_W - 8;
  localparam int INC_W  = PROD_W - 16;
  localparam int IS_W   = ((INC_W > INT_W) ? INC_W : INT_W) + 1;
  localparam int HI_SH  = 20;

  localparam int OUT_LIM = (SPEED_LIMIT < OUT_MAX) ? SPEED_LIMIT : OUT_MAX;

  localparam logic signed [SPD_W-1:0] LIM_S     = SPD_W'(SPEED_LIMIT);
  localparam logic signed [SPD_W-1:0] OUT_MAX_S = SPD_W'(OUT_MAX);
  localparam logic signed [SPD_OUT_W-1:0] OUT_LIM_S = SPD_OUT_W'(OUT_LIM);
  localparam logic signed [IS_W-1:0] INT_MAX_S = IS_W'((64'd1 << (INT_W - 1)) - 64'd1);
  localparam logic signed [IS_W-1:0] INT_MIN_S = -INT_MAX_S - IS_W'(1);

  typedef struct packed {
    logic [POS_W-1:0] target_position;
    logic [POS_W-1:0] current_position;
  } in_item_t;

  typedef struct packed {
    logic signed [SPD_OUT_W-1:0] speed;
    logic                        finished;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHK,
    ST_MUL_P,
    ST_MUL_IL,
    ST_MUL_IH,
    ST_MUL_T,
    ST_FIN,
    ST_EMIT
  } state_t;

endpackage

// ===== design/pi_position_to_speed_controller_top.sv =====
// pi position to speed controller with deadband and conditional integration
//
// input channel in_valid/in_ready carries an item with a target and a measured
// position; output channel out_valid/out_ready returns one item per input
// with a signed speed and a finished flag. configuration is a plain write port
// (cfg_write, cfg_index, cfg_data); the user must write it only while the
// block is idle, which the block itself does not enforce. one item at a time
// on one shared 21x17 multiplier: the position error is scaled and divided by
// the span as a product with a rounded-up reciprocal, 16 reciprocal bits per
// cycle (RCP_N = 3 at the default span), then the pi sum and integrator step
// run through ST_MUL_P, ST_MUL_IL, ST_MUL_IH, ST_MUL_T and ST_FIN before
// ST_EMIT. a new item is taken only once the previous one has been emitted.
// inside the deadband the item goes from ST_CHK straight to ST_EMIT; with
// feedback off it goes from idle straight to ST_EMIT.
// the result sits in an output register, so a new item is accepted while the
// receiver stalls; the block only waits at its final step if that register is
// still full. reset (synchronous, active high) restores register defaults,
// clears the integrator and drops out_valid.
module pi_position_to_speed_controller_top
  import pipsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  state_t state, state_next;

  logic [GAIN_W-1:0] prop_gain, integ_gain, step_time_q16;
  logic [DB_W-1:0]   deadband_deg_q8;
  logic [MINS_W-1:0] min_speed;
  logic              feedback_enabled;

  logic signed [INT_W-1:0] integral;

  logic                    neg;
  logic [POS_W-1:0]        pmag;
  logic [QW-1:0]           dq;
  logic [CNT_W-1:0]        cnt;
  logic signed [ERR_W-1:0] err;
  logic signed [ACC_W-1:0] acc;
  logic signed [INC_W-1:0] inc;
  logic signed [SPD_OUT_W-1:0] spd_r;
  logic                    fin_r;

  // input difference and magnitude
  logic [POS_W:0]   diff;
  logic [POS_W-1:0] mag;

  assign diff = {1'b0, in_data.target_position} - {1'b0, in_data.current_position};
  assign mag  = diff[POS_W] ? POS_W'(-diff) : POS_W'(diff);

  // quotient magnitude from the reciprocal product
  assign dq = acc[RCP_SH +: QW];

  logic in_band;
  assign in_band = dq < QW'(deadband_deg_q8);

  // shared multiplier
  logic signed [MUL_AW-1:0] mul_a;
  logic [GAIN_W-1:0]        mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [ACC_W-1:0]  acc_add;

  always_comb begin
    mul_a = MUL_AW'(err);
    mul_b = prop_gain;
    unique case (state)
      ST_DIV: begin
        mul_a = MUL_AW'($signed({1'b0, pmag}));
        mul_b = RCP_V[cnt*GAIN_W +: GAIN_W];
      end
      ST_MUL_IL: begin
        mul_a = $signed(MUL_AW'(integral[HI_SH-1:0]));
        mul_b = integ_gain;
      end
      ST_MUL_IH: begin
        mul_a = MUL_AW'($signed(integral[INT_W-1:HI_SH]));
        mul_b = integ_gain;
      end
      ST_MUL_T: begin
        mul_a = MUL_AW'(err);
        mul_b = step_time_q16;
      end
      default: begin
        mul_a = MUL_AW'(err);
        mul_b = prop_gain;
      end
    endcase
  end

  assign prod     = mul_a * $signed({1'b0, mul_b});
  assign prod_rnd = prod + (prod[PROD_W-1] ? PROD_W'(16'hFFFF) : PROD_W'(0));
  assign acc_add  = (state == ST_MUL_IH) ? (ACC_W'(prod) <<< HI_SH) : ACC_W'(prod);

  // final rounding, clamp and raise
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [SPD_W-1:0] spd_w, spd_c, spd_o, min_s, raise_s;
  logic                    adjusted;
  logic signed [IS_W-1:0]  isum;
  logic signed [INT_W-1:0] int_sat;

  assign acc_rnd = acc + (acc[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
  assign spd_w   = SPD_W'(acc_rnd >>> 8);
  assign min_s   = $signed(SPD_W'(min_speed));
  assign raise_s = (min_s > LIM_S) ? LIM_S : min_s;

  always_comb begin
    adjusted = 1'b1;
    if (spd_w > LIM_S) begin
      spd_c = LIM_S;
    end else if (spd_w < -LIM_S) begin
      spd_c = -LIM_S;
    end else if (spd_w > 0 && spd_w < min_s) begin
      spd_c = raise_s;
    end else if (spd_w < 0 && spd_w > -min_s) begin
      spd_c = -raise_s;
    end else begin
      spd_c    = spd_w;
      adjusted = 1'b0;
    end
    if (spd_c > OUT_MAX_S) begin
      spd_o = OUT_MAX_S;
    end else if (spd_c < -OUT_MAX_S) begin
      spd_o = -OUT_MAX_S;
    end else begin
      spd_o = spd_c;
    end
  end

  assign isum = IS_W'(integral) + IS_W'(inc);

  always_comb begin
    if (isum > INT_MAX_S) begin
      int_sat = INT_W'(INT_MAX_S);
    end else if (isum < INT_MIN_S) begin
      int_sat = INT_W'(INT_MIN_S);
    end else begin
      int_sat = INT_W'(isum);
    end
  end

  logic emit_go;
  assign emit_go = !out_valid || out_ready;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = feedback_enabled ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (cnt == '0) begin
          state_next = ST_CHK;
        end
      end
      ST_CHK:    state_next = in_band ? ST_EMIT : ST_MUL_P;
      ST_MUL_P:  state_next = ST_MUL_IL;
      ST_MUL_IL: state_next = ST_MUL_IH;
      ST_MUL_IH: state_next = ST_MUL_T;
      ST_MUL_T:  state_next = ST_FIN;
      ST_FIN:    state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain        <= '0;
      integ_gain       <= '0;
      step_time_q16    <= GAIN_W'(655);
      deadband_deg_q8  <= DB_W'(256);
      min_speed        <= '0;
      feedback_enabled <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  prop_gain        <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN: integ_gain       <= cfg_data[GAIN_W-1:0];
        REG_STEP_TIME:  step_time_q16    <= cfg_data[GAIN_W-1:0];
        REG_DEADBAND:   deadband_deg_q8  <= cfg_data[DB_W-1:0];
        REG_MIN_SPEED:  min_speed        <= cfg_data[MINS_W-1:0];
        REG_FEEDBACK:   feedback_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // integrator and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      integral  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_FIN && !adjusted) begin
        integral <= int_sat;
      end
      if (state == ST_EMIT && emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && emit_go) begin
      out_data.speed    <= spd_r;
      out_data.finished <= fin_r;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        neg   <= diff[POS_W];
        pmag  <= mag;
        acc   <= '0;
        cnt   <= CNT_W'(RCP_N - 1);
        spd_r <= '0;
        fin_r <= 1'b0;
      end
      // reciprocal chunks, most significant first
      ST_DIV: begin
        acc <= (acc <<< GAIN_W) + acc_add;
        cnt <= cnt - CNT_W'(1);
      end
      ST_CHK: begin
        err   <= neg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
        spd_r <= '0;
        fin_r <= in_band;
      end
      ST_MUL_P:  acc <= acc_add;
      ST_MUL_IL: acc <= acc + acc_add;
      ST_MUL_IH: acc <= acc + acc_add;
      ST_MUL_T:  inc <= INC_W'(prod_rnd >>> 16);
      ST_FIN: begin
        spd_r <= SPD_OUT_W'(spd_o);
        fin_r <= 1'b0;
      end
      ST_EMIT: ;
      default: ;
    endcase
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("block ready right after taking an item");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.speed <= OUT_LIM_S) && (out_data.speed >= -OUT_LIM_S))
    else $error("speed outside limit");

  a_finished_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.finished) |-> (out_data.speed == '0))
    else $error("finished item with nonzero speed");

  a_integral_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_FIN) |=> (integral == $past(integral)))
    else $error("integrator changed outside final step");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && cnt != '0) |=> (state == ST_DIV))
    else $error("divider left early");

endmodule
